/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL files.
// Clock clk and reset rst are taken from the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CHK_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define CHK_ASSERT(lbl, prop, msg)
`define CHK_NEVER(lbl, expr, msg)
`endif
`endif

/* rtl/mciir_pkg.sv */
// Types and constants for the multichannel direct form I IIR filter.
// No dependencies.
package mciir_pkg;

  localparam int SMP_W      = 16;  // Q1.15 samples
  localparam int COEF_W     = 16;  // Q2.14 coefficients
  localparam int NUM_COEFS  = 3;   // coefficient registers per side
  localparam int ACC_W      = 36;  // exact sum of up to five Q3.29 products
  localparam int PROD_W     = 2 * SMP_W;
  localparam int QUO_W      = 17;  // quotient bits kept below the saturation check
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int LEN_W      = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NUM_LEN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEN_LEN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B0      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_B1      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_B2      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_A0      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_A1      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_A2      = 3'd7;

  typedef logic signed [SMP_W-1:0]  sample_t;
  typedef logic signed [COEF_W-1:0] coef_t;

  // one multiply-accumulate term as seen by the shared multiplier
  typedef struct packed {
    coef_t   coef;
    sample_t hist;
    logic    en;   // tap active under num_len / den_len
    logic    sub;  // feedback term, subtracted
  } term_t;

endpackage

/* rtl/multichannel_iir_direct_form_one.sv */
// Multichannel direct form I IIR filter, one shared multiplier and divider.
// Each accepted word runs through LOAD, MAC, ABS, CHK, the bit-serial divider DIV
// and FIN; DIV is skipped when a0 is zero or the quotient overflows.
// One word in flight: a new word is accepted only once the last one has left FIN,
// and FIN waits while the output register holds a word that is not taken.
// Synchronous active-high reset: coefficients to defaults, all histories read zero.
`include "assert_macros.svh"

module multichannel_iir_direct_form_one #(
  parameter int CHANNELS = 2,
  parameter int MAX_TAPS = 3
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration write port
  input  logic                                cfg_wen,
  input  logic [mciir_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mciir_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  // input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [15:0]                         s_axis_tdata,   // [15:0] sample_in
  input  logic [0:0]                          s_axis_tuser,   // [0] chan
  // output stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [15:0]                         m_axis_tdata,   // [15:0] sample_out
  output logic [2:0]                          m_axis_tuser    // [0] chan_out [1] sat_flag
                                                              // [2] div_zero
);
  import mciir_pkg::*;

  // Only the taps that have coefficients are kept in the history rows.
  localparam int XT    = (MAX_TAPS < NUM_COEFS) ? MAX_TAPS : NUM_COEFS;
  localparam int YT    = (MAX_TAPS - 1 < NUM_COEFS - 1) ? MAX_TAPS - 1 : NUM_COEFS - 1;
  localparam int YS    = (YT > 0) ? YT : 1;
  localparam int TERMS = XT + YT;
  localparam int KW    = $clog2(TERMS + 1);
  localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int DCW   = $clog2(QUO_W);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_MAC  = 3'd2;
  localparam logic [2:0] ST_ABS  = 3'd3;
  localparam logic [2:0] ST_CHK  = 3'd4;
  localparam logic [2:0] ST_DIV  = 3'd5;
  localparam logic [2:0] ST_FIN  = 3'd6;

  // configuration registers
  logic [LEN_W-1:0] num_len;
  logic [LEN_W-1:0] den_len;
  coef_t            bcoef [NUM_COEFS];
  coef_t            acoef [NUM_COEFS];

  // per-channel history rows, newest tap in the lowest slice
  logic [XT*SMP_W-1:0] xmem [CHANNELS];
  logic [YS*SMP_W-1:0] ymem [CHANNELS];
  logic [CHANNELS-1:0] row_valid;
  logic [XT*SMP_W-1:0] xrd;
  logic [YS*SMP_W-1:0] yrd;
  logic                rvalid;

  logic [2:0]          state;
  logic [CW-1:0]       chidx;
  logic [CW-1:0]       ch;
  sample_t             sample_q;
  sample_t             xw [XT];
  sample_t             yw [YS];
  logic [XT*SMP_W-1:0] xpack;
  logic [YS*SMP_W-1:0] ypack;

  // MAC datapath
  term_t                     term [TERMS];
  term_t                     term_cur;
  logic [KW-1:0]             k;
  logic signed [PROD_W-1:0]  prod_cur;
  logic signed [PROD_W-1:0]  prod;
  logic                      prod_sub;
  logic                      prod_vld;
  logic signed [ACC_W-1:0]   acc;

  // divider
  logic [ACC_W-1:0]   mag;
  logic [SMP_W-1:0]   dmag;
  logic               neg;
  logic               dz;
  logic [SMP_W-1:0]   rem;
  logic [QUO_W-1:0]   dvd;      // dividend bits in, quotient bits out
  logic [DCW-1:0]     dcnt;
  logic [SMP_W:0]     trial;
  logic               fin_go;

  sample_t            y_res;
  logic               sat_res;

  // output register
  logic               ovalid;
  logic [15:0]        odata;
  logic [2:0]         ouser;

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = ovalid;
  assign m_axis_tdata  = odata;
  assign m_axis_tuser  = ouser;

  // chan taken modulo CHANNELS; a 1-bit chan only folds when there is one channel
  assign chidx  = (CHANNELS > 1) ? CW'(s_axis_tuser) : '0;
  assign fin_go = !ovalid || m_axis_tready;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      num_len  <= LEN_W'(3);
      den_len  <= LEN_W'(1);
      bcoef[0] <= 16'sd16384;
      bcoef[1] <= '0;
      bcoef[2] <= '0;
      acoef[0] <= 16'sd16384;
      acoef[1] <= '0;
      acoef[2] <= '0;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_NUM_LEN: num_len  <= cfg_wdata[LEN_W-1:0];
        REG_DEN_LEN: den_len  <= cfg_wdata[LEN_W-1:0];
        REG_B0:      bcoef[0] <= cfg_wdata;
        REG_B1:      bcoef[1] <= cfg_wdata;
        REG_B2:      bcoef[2] <= cfg_wdata;
        REG_A0:      acoef[0] <= cfg_wdata;
        REG_A1:      acoef[1] <= cfg_wdata;
        REG_A2:      acoef[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // term table: feedforward taps first, then feedback taps 1..YT
  for (genvar t = 0; t < TERMS; t++) begin : g_term
    if (t < XT) begin : g_ff
      assign term[t].coef = bcoef[t];
      assign term[t].hist = xw[t];
      assign term[t].en   = (int'(num_len) > t);
      assign term[t].sub  = 1'b0;
    end else begin : g_fb
      localparam int J = t - XT + 1;
      assign term[t].coef = acoef[J];
      assign term[t].hist = yw[J-1];
      assign term[t].en   = (int'(den_len) > J);
      assign term[t].sub  = 1'b1;
    end
  end

  always_comb begin
    term_cur = '0;
    for (int t = 0; t < TERMS; t++) begin
      if (k == KW'(t)) term_cur = term[t];
    end
  end

  // signed 16x16 product of the selected term
  assign prod_cur = $signed(term_cur.coef) * $signed(term_cur.hist);

  // new rows to write back: input already shifted in LOAD, output shifts here
  always_comb begin
    for (int i = 0; i < XT; i++) xpack[i*SMP_W +: SMP_W] = xw[i];
    ypack[SMP_W-1:0] = y_res;
    for (int i = 1; i < YS; i++) ypack[i*SMP_W +: SMP_W] = yw[i-1];
  end

  assign trial = {rem, dvd[QUO_W-1]};

  // final quotient to signed saturated sample
  always_comb begin
    if (neg) begin
      sat_res = (dvd > QUO_W'(32768));
      y_res   = sat_res ? sample_t'(-32768) : sample_t'(-dvd[SMP_W-1:0]);
    end else begin
      sat_res = (dvd > QUO_W'(32767));
      y_res   = sat_res ? sample_t'(32767) : sample_t'(dvd[SMP_W-1:0]);
    end
  end

  // history memories
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      xrd <= xmem[chidx];
      yrd <= ymem[chidx];
    end
    if (state == ST_FIN && fin_go) begin
      xmem[ch] <= xpack;
      ymem[ch] <= ypack;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      row_valid <= '0;
      ovalid    <= 1'b0;
      k         <= '0;
      prod_vld  <= 1'b0;
      dcnt      <= '0;
    end else begin
      // a word taken while FIN loads the next one is replaced there
      if (ovalid && m_axis_tready && state != ST_FIN) ovalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            ch       <= chidx;
            sample_q <= sample_t'(s_axis_tdata);
            rvalid   <= row_valid[chidx];
            state    <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          xw[0] <= sample_q;
          for (int i = 1; i < XT; i++)
            xw[i] <= rvalid ? sample_t'(xrd[(i-1)*SMP_W +: SMP_W]) : '0;
          for (int i = 0; i < YS; i++)
            yw[i] <= rvalid ? sample_t'(yrd[i*SMP_W +: SMP_W]) : '0;
          k        <= '0;
          acc      <= '0;
          prod_vld <= 1'b0;
          state    <= ST_MAC;
        end
        ST_MAC: begin
          // product of term k registered, accumulated in the cycle after
          if (prod_vld) begin
            if (prod_sub) acc <= acc - ACC_W'(prod);
            else          acc <= acc + ACC_W'(prod);
          end
          if (k == KW'(TERMS)) begin
            prod_vld <= 1'b0;
            state    <= ST_ABS;
          end else begin
            prod     <= term_cur.en ? prod_cur : '0;
            prod_sub <= term_cur.sub;
            prod_vld <= 1'b1;
            k        <= k + KW'(1);
          end
        end
        ST_ABS: begin
          mag   <= acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
          dmag  <= acoef[0][COEF_W-1] ? SMP_W'(-acoef[0]) : SMP_W'(acoef[0]);
          neg   <= acc[ACC_W-1] ^ acoef[0][COEF_W-1];
          dz    <= (acoef[0] == '0);
          state <= ST_CHK;
        end
        ST_CHK: begin
          if (dz) begin
            dvd   <= '0;
            neg   <= 1'b0;
            state <= ST_FIN;
          end else if (mag[ACC_W-1:QUO_W] >= (ACC_W-QUO_W)'(dmag)) begin
            // quotient at least 2^17: saturates either way
            dvd   <= '1;
            state <= ST_FIN;
          end else begin
            rem   <= mag[QUO_W+SMP_W-1:QUO_W];
            dvd   <= mag[QUO_W-1:0];
            dcnt  <= DCW'(QUO_W - 1);
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          // restoring division, one quotient bit per cycle
          if (trial >= {1'b0, dmag}) begin
            rem <= SMP_W'(trial - {1'b0, dmag});
            dvd <= {dvd[QUO_W-2:0], 1'b1};
          end else begin
            rem <= trial[SMP_W-1:0];
            dvd <= {dvd[QUO_W-2:0], 1'b0};
          end
          if (dcnt == '0) state <= ST_FIN;
          else            dcnt  <= dcnt - DCW'(1);
        end
        ST_FIN: begin
          if (fin_go) begin
            row_valid[ch] <= 1'b1;
            ovalid        <= 1'b1;
            odata         <= y_res;
            ouser         <= {dz, sat_res && !dz, ch[0]};
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // checks
  `CHK_ASSERT(a_one_in_flight, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready, "accepted a second word while busy")
  `CHK_NEVER(a_flags_exclusive, m_axis_tvalid && m_axis_tuser[1] && m_axis_tuser[2], "sat_flag with div_zero")
  `CHK_ASSERT(a_dz_zero_out, (m_axis_tvalid && m_axis_tuser[2]) |-> (m_axis_tdata == '0), "nonzero output on zero a0")
  `CHK_ASSERT(a_rem_bound, (state == ST_DIV) |-> (rem < dmag), "divider remainder out of range")

endmodule

/* test/tb_top.sv */
// Self-checking testbench for the multichannel direct form I IIR filter.
// Depends on mciir_pkg and multichannel_iir_direct_form_one; runs a directed
// table, then randomized traffic, checking every output word against a predictor.
module tb_top;
  import mciir_pkg::*;

  localparam int NCH             = 2;
  localparam int NTAPS           = 3;
  localparam int PHASES          = 6;
  localparam int WORDS_PER_PHASE = 180;
  localparam int STALL_LIMIT     = 3000;  // cycles with no handshake or register write
  localparam int DRAIN_CYCLES    = 40;    // drain time after the last word, with margin

  logic                  clk           = 1'b0;
  logic                  rst           = 1'b1;
  logic                  cfg_wen       = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index     = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata     = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [15:0]           s_axis_tdata  = '0;  // [15:0] sample_in
  logic [0:0]            s_axis_tuser  = '0;  // [0] chan
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [15:0]           m_axis_tdata;        // [15:0] sample_out
  logic [2:0]            m_axis_tuser;        // [0] chan_out [1] sat_flag [2] div_zero

  // one filtered output word, field by field
  typedef struct packed {
    logic    chan;
    sample_t smp;
    logic    sat;
    logic    dz;
  } filt_word_t;

  // one row of the directed table: either a register write or an input word
  typedef struct {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
    logic                  chan;
    sample_t               smp;
    bit                    typed;  // expected word given in the table
    filt_word_t            want;
  } stim_row_t;

  // predictor copy of the configuration and the per-channel histories
  logic [LEN_W-1:0] num_taps;
  logic [LEN_W-1:0] den_taps;
  coef_t            coef_b [NUM_COEFS];
  coef_t            coef_a [NUM_COEFS];
  sample_t          x_hist [NCH][NTAPS];
  sample_t          y_hist [NCH][NTAPS-1];

  filt_word_t pending_words [$];  // expected output words, oldest first
  stim_row_t  dir_rows [$];
  int         mismatches   = 0;
  int         send_idle    = 0;   // percent of cycles the sender holds off
  int         recv_idle    = 0;   // percent of cycles the receiver stalls
  int         stall_cycles = 0;

  multichannel_iir_direct_form_one #(
    .CHANNELS(NCH),
    .MAX_TAPS(NTAPS)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wen      (cfg_wen),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic flag_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatches++;
  endtask

  // Filter one sample: shift it into the channel's input history, sum the
  // feedforward products, subtract the feedback products, divide by a0
  // (truncating toward zero), saturate, then shift the result into y history.
  function automatic filt_word_t filter_step(input logic ch, input sample_t smp);
    longint     acc;
    longint     quo;
    filt_word_t r;
    int         i;
    acc    = 0;
    r      = '0;
    r.chan = ch;
    for (i = NTAPS - 1; i > 0; i--) x_hist[ch][i] = x_hist[ch][i-1];
    x_hist[ch][0] = smp;
    for (i = 0; i < NTAPS; i++)
      if (i < num_taps) acc += longint'(coef_b[i]) * longint'(x_hist[ch][i]);
    // den_len of zero or one leaves the feedback side unused
    for (i = 1; i < NTAPS; i++)
      if (i < den_taps) acc -= longint'(coef_a[i]) * longint'(y_hist[ch][i-1]);
    if (coef_a[0] == '0) begin
      // zero divisor: output forced to zero, flagged, and zero goes into y history
      r.dz = 1'b1;
    end else begin
      quo = acc / longint'(coef_a[0]);
      if (quo > 32767) begin
        quo   = 32767;
        r.sat = 1'b1;
      end else if (quo < -32768) begin
        quo   = -32768;
        r.sat = 1'b1;
      end
      r.smp = quo[SMP_W-1:0];
    end
    for (i = NTAPS - 2; i > 0; i--) y_hist[ch][i] = y_hist[ch][i-1];
    y_hist[ch][0] = r.smp;
    return r;
  endfunction

  function automatic sample_t rand_sample;
    case ($urandom_range(15))
      0:       return 16'sh7fff;
      1:       return 16'sh8000;
      2:       return '0;
      3:       return '1;
      default: return 16'($urandom);
    endcase
  endfunction

  // moderate coefficients most often so the filter output stays interesting,
  // with extremes, zero and the full range mixed in
  function automatic logic [CFG_DATA_W-1:0] pick_coef;
    case ($urandom_range(7))
      0:       return 16'h7fff;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3, 4:    return 16'($urandom);
      default: return 16'($urandom_range(8192) - 4096);
    endcase
  endfunction

  function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
    stim_row_t row;
    row.is_cfg = 1'b1;
    row.idx    = idx;
    row.val    = val;
    row.chan   = 1'b0;
    row.smp    = '0;
    row.typed  = 1'b0;
    row.want   = '0;
    dir_rows.push_back(row);
  endfunction

  // typed = 0: expectation comes from the predictor
  function automatic void add_word(input logic ch, input sample_t smp, input bit typed,
                                   input sample_t y, input logic sat, input logic dz);
    stim_row_t row;
    row.is_cfg    = 1'b0;
    row.idx       = '0;
    row.val       = '0;
    row.chan      = ch;
    row.smp       = smp;
    row.typed     = typed;
    row.want.chan = ch;
    row.want.smp  = y;
    row.want.sat  = sat;
    row.want.dz   = dz;
    dir_rows.push_back(row);
  endfunction

  // Drive one input word from a falling edge and hold it until accepted.
  // valid is only dropped when a gap is taken, so it never toggles within a step.
  task automatic send_word(input logic ch, input sample_t smp, input bit typed,
                           input filt_word_t want);
    filt_word_t pred;
    if ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    s_axis_tuser  <= ch;
    do @(posedge clk); while (!s_axis_tready);
    // predictor always runs so the histories track the block
    pred = filter_step(ch, smp);
    pending_words.push_back(typed ? want : pred);
    @(negedge clk);
  endtask

  // hold the input side until every expected word has come back
  task automatic wait_idle;
    s_axis_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // block is idle whenever this is called; predictor copy follows the write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_NUM_LEN: num_taps  = val[LEN_W-1:0];
      REG_DEN_LEN: den_taps  = val[LEN_W-1:0];
      REG_B0:      coef_b[0] = val;
      REG_B1:      coef_b[1] = val;
      REG_B2:      coef_b[2] = val;
      REG_A0:      coef_a[0] = val;
      REG_A1:      coef_a[1] = val;
      REG_A2:      coef_a[2] = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_wen <= 1'b0;
    @(negedge clk);
  endtask

  // receiver: new ready decision every falling edge
  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle);
  end

  // output check: every accepted word against the oldest expectation
  always @(posedge clk) begin : out_check
    filt_word_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_words.size() == 0) begin
        flag_mismatch($sformatf("output word with nothing expected: chan %0d sample %0d",
                                m_axis_tuser[0], $signed(m_axis_tdata)));
      end else begin
        want = pending_words.pop_front();
        if (m_axis_tuser[0] !== want.chan)
          flag_mismatch($sformatf("chan_out got %0d expected %0d", m_axis_tuser[0],
                                  want.chan));
        if (m_axis_tdata !== want.smp)
          flag_mismatch($sformatf("sample_out got %0d expected %0d (chan %0d)",
                                  $signed(m_axis_tdata), want.smp, want.chan));
        if (m_axis_tuser[1] !== want.sat)
          flag_mismatch($sformatf("sat_flag got %0d expected %0d", m_axis_tuser[1],
                                  want.sat));
        if (m_axis_tuser[2] !== want.dz)
          flag_mismatch($sformatf("div_zero got %0d expected %0d", m_axis_tuser[2],
                                  want.dz));
      end
    end
  end

  // watchdog: any handshake or register write counts as progress
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_wen) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("multichannel_iir_direct_form_one test failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : main
    int ph;
    int n;
    int r;

    // predictor state after reset: pass-through, histories zero
    num_taps = 2'd3;
    den_taps = 2'd1;
    coef_b   = '{16'sd16384, 16'sd0, 16'sd0};
    coef_a   = '{16'sd16384, 16'sd0, 16'sd0};
    foreach (x_hist[c, t]) x_hist[c][t] = '0;
    foreach (y_hist[c, t]) y_hist[c][t] = '0;

    // --- directed table ---
    // reset defaults give y = x exactly
    add_word(1'b0, 16'sh7fff, 1, 16'sh7fff, 1'b0, 1'b0);
    add_word(1'b1, 16'sh8000, 1, 16'sh8000, 1'b0, 1'b0);
    add_word(1'b0, 16'sh0000, 1, 16'sh0000, 1'b0, 1'b0);
    add_word(1'b1, 16'sh0001, 1, 16'sh0001, 1'b0, 1'b0);
    // b0 = -2.0: gain of -2, clips at both rails
    add_cfg(REG_B0, 16'h8000);
    add_word(1'b0, 16'sh8000, 1, 16'sh7fff, 1'b1, 1'b0);
    add_word(1'b1, 16'sh7fff, 1, 16'sh8000, 1'b1, 1'b0);
    add_word(1'b0, 16'sh0001, 1, -16'sd2,   1'b0, 1'b0);
    add_word(1'b1, 16'shffff, 1, 16'sh0002, 1'b0, 1'b0);
    // zero divisor: forced zero, flagged
    add_cfg(REG_A0, 16'h0000);
    add_word(1'b0, 16'sh1234, 1, 16'sh0000, 1'b0, 1'b1);
    add_word(1'b1, 16'sh8000, 1, 16'sh0000, 1'b0, 1'b1);
    // b0 = a0 = max: unity again at the top of the coefficient range
    add_cfg(REG_A0, 16'h7fff);
    add_cfg(REG_B0, 16'h7fff);
    add_word(1'b0, 16'sh7fff, 1, 16'sh7fff, 1'b0, 1'b0);
    add_word(1'b1, 16'sh8000, 1, 16'sh8000, 1'b0, 1'b0);
    // smallest divisor: quotient = b0 * x, clips fast
    add_cfg(REG_A0, 16'h0001);
    add_word(1'b0, 16'sh0002, 1, 16'sh7fff, 1'b1, 1'b0);
    add_word(1'b1, -16'sd2,   1, 16'sh8000, 1'b1, 1'b0);
    // full feedback with extreme taps
    add_cfg(REG_A0, 16'h4000);
    add_cfg(REG_NUM_LEN, 16'd3);
    add_cfg(REG_DEN_LEN, 16'd3);
    add_cfg(REG_B0, 16'h2000);
    add_cfg(REG_B1, 16'h2000);
    add_cfg(REG_B2, 16'h8000);
    add_cfg(REG_A1, 16'h8000);
    add_cfg(REG_A2, 16'h7fff);
    add_word(1'b0, 16'sh7fff, 0, '0, 1'b0, 1'b0);
    add_word(1'b0, 16'sh8000, 0, '0, 1'b0, 1'b0);
    add_word(1'b1, 16'sh4000, 0, '0, 1'b0, 1'b0);
    add_word(1'b0, 16'sh0001, 0, '0, 1'b0, 1'b0);
    add_word(1'b1, 16'shc000, 0, '0, 1'b0, 1'b0);
    add_word(1'b0, 16'sh7fff, 0, '0, 1'b0, 1'b0);
    // den_len of zero behaves like one: no feedback
    add_cfg(REG_DEN_LEN, 16'd0);
    add_word(1'b1, 16'sh7fff, 0, '0, 1'b0, 1'b0);
    add_word(1'b0, 16'sh8000, 0, '0, 1'b0, 1'b0);
    // no taps at all on either side: output stays zero
    add_cfg(REG_NUM_LEN, 16'd0);
    add_word(1'b1, 16'sh7fff, 1, 16'sh0000, 1'b0, 1'b0);
    // negative full-scale divisor, two taps each side
    add_cfg(REG_A0, 16'h8000);
    add_cfg(REG_NUM_LEN, 16'd2);
    add_cfg(REG_DEN_LEN, 16'd2);
    add_word(1'b0, 16'sh8000, 0, '0, 1'b0, 1'b0);
    add_word(1'b1, 16'sh7fff, 0, '0, 1'b0, 1'b0);

    send_idle = 22;
    recv_idle = 58;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[k]) begin
      if (dir_rows[k].is_cfg) begin
        wait_idle();
        write_reg(dir_rows[k].idx, dir_rows[k].val);
      end else begin
        send_word(dir_rows[k].chan, dir_rows[k].smp, dir_rows[k].typed, dir_rows[k].want);
      end
    end

    // --- random phases, one register setting each ---
    for (ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      if (ph == 1 || ph == 3) begin
        // extremes: longest filter, every coefficient at one rail
        write_reg(REG_NUM_LEN, 16'd3);
        write_reg(REG_DEN_LEN, 16'd3);
        for (r = REG_B0; r <= REG_A2; r++)
          write_reg(r[CFG_IDX_W-1:0], (ph == 1) ? 16'h7fff : 16'h8000);
      end else begin
        write_reg(REG_NUM_LEN, 16'($urandom_range(3)));
        write_reg(REG_DEN_LEN, 16'($urandom_range(3)));
        write_reg(REG_B0, pick_coef());
        write_reg(REG_B1, pick_coef());
        write_reg(REG_B2, pick_coef());
        // unity divisor most of the time keeps outputs off the rails
        write_reg(REG_A0, ($urandom_range(2) == 0) ? pick_coef() : 16'h4000);
        write_reg(REG_A1, pick_coef());
        write_reg(REG_A2, pick_coef());
      end
      // receiver-heavy idling, then sender-heavy, then none
      send_idle = (ph < 2) ? 22 : (ph < 4) ? 58 : 0;
      recv_idle = (ph < 2) ? 58 : (ph < 4) ? 22 : 0;
      for (n = 0; n < WORDS_PER_PHASE; n++) begin
        // now and then let the pipe run dry before the next word
        if ($urandom_range(39) == 0) wait_idle();
        send_word(1'($urandom_range(1)), rand_sample(), 1'b0, '0);
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("multichannel_iir_direct_form_one test passed");
    end else begin
      $display("multichannel_iir_direct_form_one test failed");
    end
    $finish;
  end

endmodule
